>>> sv/adrc_first_order_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// adrc assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ADRC_FIRST_ORDER_CONTROLLER_UNIT_MACROS_SVH
`define ADRC_FIRST_ORDER_CONTROLLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ADRC_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ADRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ADRC_ASSERT_NOW(lbl, prop, msg)
`define ADRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/adrc_pkg.sv
// ----------------------------------------------------------------------------
// adrc_pkg
// shared types, register indexes, step codes and saturation helper
// ----------------------------------------------------------------------------
package adrc_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int STEP_W     = 4;
  localparam int PROD_W     = 66;
  localparam int DIV_STEPS  = 48;
  localparam int QUO_W      = 49;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WC     = 3'd0;
  localparam logic [IDX_W-1:0] REG_WO     = 3'd1;
  localparam logic [IDX_W-1:0] REG_B0     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DLO    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DHI    = 3'd5;
  localparam logic [IDX_W-1:0] REG_ULO    = 3'd6;
  localparam logic [IDX_W-1:0] REG_UHI    = 3'd7;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // sequencer steps, also the controller state codes
  localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] ST_E    = 4'd1;
  localparam logic [STEP_W-1:0] ST_B2   = 4'd2;
  localparam logic [STEP_W-1:0] ST_TD   = 4'd3;
  localparam logic [STEP_W-1:0] ST_S    = 4'd4;
  localparam logic [STEP_W-1:0] ST_Z1M  = 4'd5;
  localparam logic [STEP_W-1:0] ST_Z1   = 4'd6;
  localparam logic [STEP_W-1:0] ST_G2   = 4'd7;
  localparam logic [STEP_W-1:0] ST_Z2M  = 4'd8;
  localparam logic [STEP_W-1:0] ST_Z2   = 4'd9;
  localparam logic [STEP_W-1:0] ST_U0   = 4'd10;
  localparam logic [STEP_W-1:0] ST_DIV  = 4'd11;
  localparam logic [STEP_W-1:0] ST_FIN  = 4'd12;
  localparam logic [STEP_W-1:0] ST_LOAD = 4'd13;

  localparam logic signed [PROD_W-1:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -66'sd2147483648;

  typedef struct packed {
    logic              capture;
    logic [STEP_W-1:0] step;
    logic              div_start;
    logic              out_load;
  } adrc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } adrc_stat_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

>>> sv/adrc_in_if.sv
// ----------------------------------------------------------------------------
// adrc_in_if
// input channel: operation code, setpoint, measurement and load value
// ----------------------------------------------------------------------------
interface adrc_in_if import adrc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] load_value;

  modport source(output valid, operation, target, measured, load_value, input ready);
  modport sink(input valid, operation, target, measured, load_value, output ready);
endinterface

>>> sv/adrc_out_if.sv
// ----------------------------------------------------------------------------
// adrc_out_if
// result channel: drive, clamp flag, disturbance estimate and observer error
// ----------------------------------------------------------------------------
interface adrc_out_if import adrc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     saturated;
  logic signed [DATA_W-1:0] disturbance;
  logic signed [DATA_W-1:0] observer_error;

  modport source(output valid, drive, saturated, disturbance, observer_error, input ready);
  modport sink(input valid, drive, saturated, disturbance, observer_error, output ready);
endinterface

>>> sv/adrc_div.sv
// ----------------------------------------------------------------------------
// adrc_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module adrc_div import adrc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     busy,
  output logic                     done,
  output logic signed [QUO_W-1:0]  quot
);
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int MAG_W = DIV_STEPS;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dvs_r;
  logic [MAG_W-1:0]  quo_r;

  logic [DATA_W:0]   num_abs, den_abs, rs, diff;
  logic              ge;

  assign num_abs = num[DATA_W-1] ? -{num[DATA_W-1], num} : {1'b0, num};
  assign den_abs = den[DATA_W-1] ? -{den[DATA_W-1], den} : {1'b0, den};
  assign rs      = {rem_r, quo_r[MAG_W-1]};
  assign ge      = rs >= {1'b0, dvs_r};
  assign diff    = rs - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[DATA_W-1] ^ den[DATA_W-1];
      rem_r <= '0;
      dvs_r <= den_abs[DATA_W-1:0];
      quo_r <= {num_abs[DATA_W-1:0], 16'd0};
    end else if (busy_r) begin
      rem_r <= ge ? diff[DATA_W-1:0] : rs[DATA_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
endmodule

>>> sv/adrc_datapath.sv
// ----------------------------------------------------------------------------
// adrc_datapath
// configuration registers, observer state, shared multiplier, divider, outputs
// ----------------------------------------------------------------------------
module adrc_datapath import adrc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  adrc_cmd_t                cmd,
  output adrc_stat_t               stat,
  input  logic signed [DATA_W-1:0] in_target,
  input  logic signed [DATA_W-1:0] in_measured,
  input  logic signed [DATA_W-1:0] in_load_value,
  output logic signed [DATA_W-1:0] out_drive,
  output logic                     out_saturated,
  output logic signed [DATA_W-1:0] out_disturbance,
  output logic signed [DATA_W-1:0] out_observer_error
);
  localparam int OP_W = DATA_W + 1;

  logic [30:0]              wc_r, wo_r;
  logic signed [DATA_W-1:0] b0_r, dlo_r, dhi_r, ulo_r, uhi_r;
  logic [24:0]              dt_r;

  logic signed [DATA_W-1:0] z1_r, z2_r, prev_r;
  logic                     satf_r;

  logic signed [DATA_W-1:0] target_r, meas_r, load_r;
  logic signed [DATA_W-1:0] e_r, b2_r, td_r, s_r, z1n_r, g2_r, diff_r, z2n_r;
  logic signed [PROD_W-1:0] p_r;

  logic signed [DATA_W-1:0] drv_r, dist_r, err_r;
  logic                     sat_r;

  logic signed [OP_W-1:0]   opa, opb;
  logic signed [DATA_W-1:0] b0_eff, b1, p16, z2_sum, z2_clamp, num;
  logic signed [PROD_W-1:0] p24;
  logic signed [QUO_W-1:0]  quot, u_lo, u_clamp;
  logic                     div_busy, div_done;

  function automatic logic signed [PROD_W-1:0] sx(input logic signed [DATA_W-1:0] v);
    return PROD_W'(v);
  endfunction

  assign b0_eff = (b0_r == '0) ? 32'sd65536 : b0_r;
  assign b1     = wo_r[30] ? 32'sh7fffffff : $signed({wo_r, 1'b0});
  assign p16    = sat32(p_r >>> 16);
  assign p24    = p_r >>> 24;
  assign num    = sat32(sx(p16) - sx(z2n_r));

  always_comb begin
    z2_sum   = sat32(sx(z2_r) + p24);
    z2_clamp = (z2_sum < dlo_r) ? dlo_r : z2_sum;
    z2_clamp = (z2_clamp > dhi_r) ? dhi_r : z2_clamp;
    u_lo     = (quot < QUO_W'(ulo_r)) ? QUO_W'(ulo_r) : quot;
    u_clamp  = (u_lo > QUO_W'(uhi_r)) ? QUO_W'(uhi_r) : u_lo;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.step)
      ST_E:    begin opa = $signed({2'b00, wo_r});  opb = $signed({2'b00, wo_r}); end
      ST_B2:   begin opa = OP_W'(b0_eff);           opb = OP_W'(prev_r); end
      ST_TD:   begin opa = OP_W'(b1);               opb = OP_W'(e_r); end
      ST_Z1M:  begin opa = $signed({8'd0, dt_r});   opb = OP_W'(s_r); end
      ST_Z1:   begin opa = OP_W'(b2_r);             opb = OP_W'(e_r); end
      ST_Z2M:  begin opa = $signed({8'd0, dt_r});   opb = OP_W'(g2_r); end
      ST_Z2:   begin opa = $signed({2'b00, wc_r});  opb = OP_W'(diff_r); end
      default: begin opa = '0;                      opb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= '0;
      wo_r  <= '0;
      b0_r  <= 32'sd65536;
      dt_r  <= 25'd16777;
      dlo_r <= -32'sd65536;
      dhi_r <= 32'sd65536;
      ulo_r <= -32'sd65536;
      uhi_r <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WC:  wc_r  <= cfg_data[30:0];
        REG_WO:  wo_r  <= cfg_data[30:0];
        REG_B0:  b0_r  <= cfg_data;
        REG_DT:  dt_r  <= cfg_data[24:0];
        REG_DLO: dlo_r <= cfg_data;
        REG_DHI: dhi_r <= cfg_data;
        REG_ULO: ulo_r <= cfg_data;
        REG_UHI: uhi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // observer state, updated when the result is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r   <= '0;
      z2_r   <= '0;
      prev_r <= '0;
      satf_r <= 1'b0;
    end else if (cmd.out_load) begin
      if (cmd.step == ST_FIN) begin
        z1_r   <= z1n_r;
        z2_r   <= z2n_r;
        prev_r <= u_clamp[DATA_W-1:0];
        satf_r <= u_clamp != quot;
      end else begin
        z2_r <= load_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      target_r <= in_target;
      meas_r   <= in_measured;
      load_r   <= in_load_value;
    end
    case (cmd.step)
      ST_E:    e_r    <= sat32(sx(meas_r) - sx(z1_r));
      ST_B2:   b2_r   <= p16;
      ST_TD:   td_r   <= p16;
      ST_S:    s_r    <= sat32(sx(z2_r) + sx(td_r) + sx(p16));
      ST_Z1:   z1n_r  <= sat32(sx(z1_r) + p24);
      ST_G2: begin
        g2_r   <= p16;
        diff_r <= sat32(sx(target_r) - sx(z1n_r));
      end
      ST_Z2:   z2n_r  <= z2_clamp;
      default: ;
    endcase
    if (cmd.out_load) begin
      if (cmd.step == ST_FIN) begin
        drv_r  <= u_clamp[DATA_W-1:0];
        sat_r  <= u_clamp != quot;
        dist_r <= z2n_r;
        err_r  <= e_r;
      end else begin
        drv_r  <= prev_r;
        sat_r  <= satf_r;
        dist_r <= load_r;
        err_r  <= '0;
      end
    end
  end

  adrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (b0_eff),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.div_busy = div_busy;
  assign stat.div_done = div_done;

  assign out_drive          = drv_r;
  assign out_saturated      = sat_r;
  assign out_disturbance    = dist_r;
  assign out_observer_error = err_r;
endmodule

>>> sv/adrc_ctrl.sv
// ----------------------------------------------------------------------------
// adrc_ctrl
// sequencer that steps the datapath through one update or one load
// ----------------------------------------------------------------------------
`include "adrc_first_order_controller_unit_macros.svh"

module adrc_ctrl import adrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_operation,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  adrc_stat_t stat,
  output adrc_cmd_t  cmd
);
  logic [STEP_W-1:0] state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              room;
  logic              accept;

  assign in_ready = state_r == ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign room     = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = (in_operation == OP_LOAD) ? ST_LOAD : ST_E;
      ST_E:    state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_TD;
      ST_TD:   state_nxt = ST_S;
      ST_S:    state_nxt = ST_Z1M;
      ST_Z1M:  state_nxt = ST_Z1;
      ST_Z1:   state_nxt = ST_G2;
      ST_G2:   state_nxt = ST_Z2M;
      ST_Z2M:  state_nxt = ST_Z2;
      ST_Z2:   state_nxt = ST_U0;
      ST_U0:   state_nxt = ST_DIV;
      ST_DIV:  if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:  if (room) state_nxt = ST_IDLE;
      ST_LOAD: if (room) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture   = accept;
    cmd.step      = state_r;
    cmd.div_start = state_r == ST_U0;
    cmd.out_load  = (state_r == ST_FIN || state_r == ST_LOAD) && room;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ADRC_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE, "accept did not start work")
  `ADRC_ASSERT_NOW(a_load_has_room, cmd.out_load |-> (!out_valid_r || out_ready), "result overwritten")
  `ADRC_ASSERT_NOW(a_valid_from_load, $rose(out_valid_r) |-> $past(cmd.out_load), "valid without result")
  `ADRC_ASSERT_NOW(a_div_in_div_state, stat.div_busy |-> state_r == ST_DIV, "divider busy out of step")
endmodule

>>> sv/adrc_first_order_controller_unit.sv
// ----------------------------------------------------------------------------
// adrc_first_order_controller_unit
// first-order linear active disturbance rejection controller, Q16.16
// ----------------------------------------------------------------------------
// in_chan carries one transaction per control step: operation 0 runs the
// observer and computes the drive, operation 1 loads the disturbance estimate.
// out_chan returns exactly one transaction for each accepted input.
// cfg_we/cfg_index/cfg_data write the eight tuning registers; write only
// while no transaction is in flight.
// An update runs from accept through the steps on the shared 33x33 multiplier,
// then through the one-bit-per-cycle divider, which forms 48 quotient bits
// for the division by plant gain, then a final step clamps and commits.
// A load goes from accept through the load step into the output register.
// A new input is taken once the previous one has been moved to the output
// register, so the unit takes no new input while one is still in flight.
// When the receiver stalls, the result waits in the output register and the
// next transaction runs up to its final step, then holds until there is room.
// Reset (synchronous, rst_n low) restores register defaults and zeroes the
// observer state, the last drive and the clamp flag.
// ----------------------------------------------------------------------------
module adrc_first_order_controller_unit import adrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  adrc_in_if.sink           in_chan,
  adrc_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);
  adrc_cmd_t  cmd;
  adrc_stat_t stat;

  adrc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .stat         (stat),
    .cmd          (cmd)
  );

  adrc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .stat               (stat),
    .in_target          (in_chan.target),
    .in_measured        (in_chan.measured),
    .in_load_value      (in_chan.load_value),
    .out_drive          (out_chan.drive),
    .out_saturated      (out_chan.saturated),
    .out_disturbance    (out_chan.disturbance),
    .out_observer_error (out_chan.observer_error)
  );
endmodule

>>> tb/sv/adrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrc_checker
// watches both channels, predicts each result of the controller from its own
// copy of the tuning registers and observer state, and compares field by field
// ----------------------------------------------------------------------------
module adrc_checker import adrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_operation,
  input  logic [31:0]       in_target,
  input  logic [31:0]       in_measured,
  input  logic [31:0]       in_load_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [31:0]       out_drive,
  input  logic              out_saturated,
  input  logic [31:0]       out_disturbance,
  input  logic [31:0]       out_observer_error,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [31:0] drive;
    logic        saturated;
    logic [31:0] disturbance;
    logic [31:0] observer_error;
  } ctrl_result_t;

  ctrl_result_t expected_results[$];

  longint wc_r, wo_r, b0_r, dt_r, dlo_r, dhi_r, ulo_r, uhi_r;
  longint z1_q, z2_q, drive_q;
  logic   sat_q;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // arithmetic shift right on longint is a floor division
  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint fl24(longint v);
    return v >>> 24;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    longint r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  task automatic predict_control(input logic op, input logic [31:0] tgt,
                                 input logic [31:0] meas, input logic [31:0] ld);
    ctrl_result_t r;
    longint b0, b1, b2, e, td, tc, s, z1, g2, z2, u0, num, q, u;
    if (op == OP_LOAD) begin
      z2_q = longint'($signed(ld));
      r.drive = drive_q[31:0];
      r.saturated = sat_q;
      r.disturbance = ld;
      r.observer_error = '0;
    end else begin
      b0 = (b0_r == 0) ? 65536 : b0_r;
      b1 = clip32(2 * wo_r);
      b2 = clip32(fl16(wo_r * wo_r));
      e  = clip32(longint'($signed(meas)) - z1_q);
      td = clip32(fl16(b0 * drive_q));
      tc = clip32(fl16(b1 * e));
      s  = clip32(z2_q + td + tc);
      z1 = clip32(z1_q + fl24(dt_r * s));
      g2 = clip32(fl16(b2 * e));
      z2 = limit(clip32(z2_q + fl24(dt_r * g2)), dlo_r, dhi_r);
      u0 = clip32(fl16(wc_r * clip32(longint'($signed(tgt)) - z1)));
      num = clip32(u0 - z2);
      q = (num * 65536) / b0;
      u = limit(q, ulo_r, uhi_r);
      z1_q = z1;
      z2_q = z2;
      drive_q = u;
      sat_q = (u != q);
      r.drive = u[31:0];
      r.saturated = sat_q;
      r.disturbance = z2[31:0];
      r.observer_error = e[31:0];
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    ctrl_result_t w;
    if (!rst_n) begin
      wc_r = 0; wo_r = 0; b0_r = 65536; dt_r = 16777;
      dlo_r = -65536; dhi_r = 65536; ulo_r = -65536; uhi_r = 65536;
      z1_q = 0; z2_q = 0; drive_q = 0; sat_q = 0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WC:  wc_r  = longint'(cfg_data[30:0]);
          REG_WO:  wo_r  = longint'(cfg_data[30:0]);
          REG_B0:  b0_r  = longint'($signed(cfg_data));
          REG_DT:  dt_r  = longint'(cfg_data[24:0]);
          REG_DLO: dlo_r = longint'($signed(cfg_data));
          REG_DHI: dhi_r = longint'($signed(cfg_data));
          REG_ULO: ulo_r = longint'($signed(cfg_data));
          REG_UHI: uhi_r = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", out_drive, '0);
        end else begin
          w = expected_results.pop_front();
          if (out_drive !== w.drive) report_mismatch("drive", out_drive, w.drive);
          if (out_saturated !== w.saturated)
            report_mismatch("saturated", 32'(out_saturated), 32'(w.saturated));
          if (out_disturbance !== w.disturbance)
            report_mismatch("disturbance", out_disturbance, w.disturbance);
          if (out_observer_error !== w.observer_error)
            report_mismatch("observer_error", out_observer_error, w.observer_error);
        end
      end
      if (in_valid && in_ready)
        predict_control(in_operation, in_target, in_measured, in_load_value);
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives directed and random control steps through the adrc controller in
// several tuning phases, with random gaps and stalls; the checker compares
// ----------------------------------------------------------------------------
module testbench;
  import adrc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  int errors, pending;
  bit hold_sink = 1'b0;
  bit stim_done = 1'b0;

  adrc_in_if  in_chan();
  adrc_out_if out_chan();

  adrc_first_order_controller_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  adrc_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .in_operation(in_chan.operation), .in_target(in_chan.target),
    .in_measured(in_chan.measured), .in_load_value(in_chan.load_value),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .out_drive(out_chan.drive), .out_saturated(out_chan.saturated),
    .out_disturbance(out_chan.disturbance), .out_observer_error(out_chan.observer_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.operation = OP_UPDATE;
    in_chan.target = '0;
    in_chan.measured = '0;
    in_chan.load_value = '0;
    out_chan.ready = 1'b0;
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'($signed($urandom_range(0, 600000)) - 300000);
      default: return $urandom;
    endcase
  endfunction

  // valid stays up after an accept so that back to back offers need no gap
  task automatic send_item(input logic op, input logic [31:0] tgt,
                           input logic [31:0] meas, input logic [31:0] ld, input bit gap);
    int wait_n;
    wait_n = gap ? $urandom_range(0, 17) : 0;
    if (wait_n != 0) begin
      in_chan.valid <= 1'b0;
      repeat (wait_n) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.target <= tgt;
    in_chan.measured <= meas;
    in_chan.load_value <= ld;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic tune(input logic [31:0] wc, input logic [31:0] wo, input logic [31:0] b0,
                      input logic [31:0] dt, input logic [31:0] dlo, input logic [31:0] dhi,
                      input logic [31:0] ulo, input logic [31:0] uhi);
    write_reg(REG_WC, wc);
    write_reg(REG_WO, wo);
    write_reg(REG_B0, b0);
    write_reg(REG_DT, dt);
    write_reg(REG_DLO, dlo);
    write_reg(REG_DHI, dhi);
    write_reg(REG_ULO, ulo);
    write_reg(REG_UHI, uhi);
  endtask

  // receiver: random stall per transaction, plus a long hold-off on request
  initial begin
    int stall_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_chan.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_sink = 1'b0;
      end
      stall_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall_n != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall_n - 1) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
        while (!out_chan.valid) @(posedge clk);
      end
    end
  end

  task automatic random_phase(input int n);
    int r;
    bit gap;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      gap = ((i / 40) % 3) != 0;
      send_item((r == 0) ? OP_LOAD : OP_UPDATE, rand_value(), rand_value(),
                rand_value(), gap);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: defaults, extremes and loads
    send_item(OP_UPDATE, 32'h00010000, 32'h0, 32'h0, 1'b0);
    send_item(OP_LOAD, 32'h0, 32'h0, 32'h7fffffff, 1'b0);
    send_item(OP_UPDATE, 32'h7fffffff, 32'h80000000, 32'h0, 1'b0);
    send_item(OP_LOAD, 32'h0, 32'h0, 32'h80000000, 1'b0);
    send_item(OP_UPDATE, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0);
    drain();
    tune(32'h7fffffff, 32'h7fffffff, 32'h0, 32'h1ffffff, 32'h80000000, 32'h7fffffff,
         32'h80000000, 32'h7fffffff);
    send_item(OP_UPDATE, 32'h7fffffff, 32'h80000000, 32'h0, 1'b0);
    send_item(OP_UPDATE, 32'h80000000, 32'h7fffffff, 32'h0, 1'b0);
    send_item(OP_LOAD, 32'h0, 32'h0, 32'h12345678, 1'b0);
    send_item(OP_UPDATE, 32'h00050000, 32'h00010000, 32'h0, 1'b0);
    drain();
    // crossed limits, tiny plant gain, full period
    tune(32'h00020000, 32'h00030000, 32'h00000001, 32'h1000000, 32'h00010000,
         32'hffff0000, 32'h00020000, 32'hfffe0000);
    for (int i = 0; i < 6; i++) send_item(OP_UPDATE, rand_value(), rand_value(), 0, 1'b1);
    drain();
    tune(32'h00010000, 32'h00008000, 32'hffff0000, 32'h0, 32'hffff0000, 32'h00010000,
         32'hfff00000, 32'h00100000);
    for (int i = 0; i < 4; i++) send_item(OP_UPDATE, rand_value(), rand_value(), 0, 1'b1);
    drain();
    // random phases, one with a long receiver hold-off
    for (int p = 0; p < 6; p++) begin
      tune($urandom_range(0, 5) == 0 ? 32'h7fffffff : $urandom_range(0, 20) << 16,
           $urandom_range(0, 5) == 0 ? 32'h7fffffff : $urandom_range(0, 30) << 16,
           rand_value(), $urandom_range(0, 5) == 0 ? 32'h1ffffff : $urandom_range(0, 1 << 24),
           32'($signed(-$urandom_range(1, 100)) <<< 16), $urandom_range(0, 100) << 16,
           32'($signed(-$urandom_range(1, 50)) <<< 16), $urandom_range(0, 50) << 16);
      if (p == 2) hold_sink = 1'b1;
      random_phase(235);
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(negedge clk);
    if (errors == 0) begin
      $display("** adrc_first_order_controller_unit: PASSED **");
    end else begin
      $display("** adrc_first_order_controller_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** adrc_first_order_controller_unit: FAILED **");
    $finish;
  end

endmodule
